/* src/coap_mp_pkg.sv */
package coap_mp_pkg;

  // Longest token accepted in the header
  localparam int unsigned TOKEN_MAX = 8;

  localparam logic [7:0]  MARKER_BYTE   = 8'hFF;
  localparam logic [3:0]  NIB_EXT_1B    = 4'd13;
  localparam logic [3:0]  NIB_EXT_2B    = 4'd14;
  localparam logic [3:0]  NIB_RESERVED  = 4'd15;
  localparam logic [16:0] EXT_1B_OFFSET = 17'd13;
  localparam logic [16:0] EXT_2B_OFFSET = 17'd269;
  localparam logic [1:0]  COAP_VERSION  = 2'd1;
  localparam logic [1:0]  TYPE_ACK      = 2'd2;
  localparam logic [1:0]  TYPE_RST      = 2'd3;

  localparam int unsigned APB_AW = 3;
  localparam logic REG_URI_NUMBER = 1'b0;
  localparam logic REG_URI_MAX    = 1'b1;

  localparam logic [15:0] URI_NUMBER_RST = 16'd11;
  localparam logic [7:0]  URI_MAX_RST    = 8'd32;

  typedef enum logic [3:0] {
    PH_HDR  = 4'd0,
    PH_TOK  = 4'd1,
    PH_HEAD = 4'd2,
    PH_D13  = 4'd3,
    PH_D14H = 4'd4,
    PH_D14L = 4'd5,
    PH_L13  = 4'd6,
    PH_L14H = 4'd7,
    PH_L14L = 4'd8,
    PH_VAL  = 4'd9,
    PH_PAY  = 4'd10,
    PH_IGN  = 4'd11
  } phase_e;

  typedef enum logic [2:0] {
    ROLE_HEADER  = 3'd0,
    ROLE_TOKEN   = 3'd1,
    ROLE_OPT_HD  = 3'd2,
    ROLE_OPT_EXT = 3'd3,
    ROLE_OPT_VAL = 3'd4,
    ROLE_MARKER  = 3'd5,
    ROLE_PAYLOAD = 3'd6,
    ROLE_IGNORED = 3'd7
  } role_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_VERSION   = 3'd1,
    ST_FORMAT    = 3'd2,
    ST_PATH_LONG = 3'd3,
    ST_ACK       = 3'd4,
    ST_BAD_TYPE  = 3'd5,
    ST_TRUNCATED = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  byte_role;
    logic [7:0]  byte_value;
    logic [15:0] option_number;
    logic        message_done;
    logic [2:0]  status;
    logic [1:0]  msg_type;
    logic [3:0]  token_length;
    logic [7:0]  request_code;
    logic [15:0] message_id;
    logic [7:0]  uri_path_len;
  } out_item_t;

  typedef struct packed {
    logic [15:0] uri_option_number;
    logic [7:0]  uri_max_length;
  } cfg_t;

  // First error wins
  function automatic status_e first_err(status_e cur, status_e code);
    first_err = (cur == ST_OK) ? code : cur;
  endfunction

endpackage

/* src/coap_mp_apb.sv */
module coap_mp_apb (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [coap_mp_pkg::APB_AW-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output coap_mp_pkg::cfg_t                cfg_o
);

  coap_mp_pkg::cfg_t cfg_q, cfg_d;
  logic              wr_en;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        coap_mp_pkg::REG_URI_NUMBER: cfg_d.uri_option_number = pwdata[15:0];
        coap_mp_pkg::REG_URI_MAX:    cfg_d.uri_max_length    = pwdata[7:0];
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.uri_option_number <= coap_mp_pkg::URI_NUMBER_RST;
      cfg_q.uri_max_length    <= coap_mp_pkg::URI_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_sel)
      coap_mp_pkg::REG_URI_NUMBER: prdata = {16'd0, cfg_q.uri_option_number};
      coap_mp_pkg::REG_URI_MAX:    prdata = {24'd0, cfg_q.uri_max_length};
      default:                     prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* src/coap_mp_parse.sv */
module coap_mp_parse (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  coap_mp_pkg::in_item_t  item_i,
  input  coap_mp_pkg::cfg_t      cfg_i,
  output coap_mp_pkg::out_item_t res_o
);

  coap_mp_pkg::phase_e  phase_q, phase_d;
  coap_mp_pkg::status_e status_q, status_d;
  logic [1:0]  hdr_idx_q, hdr_idx_d;
  logic [1:0]  type_q, type_d;
  logic [3:0]  tok_len_q, tok_len_d;
  logic [7:0]  code_q, code_d;
  logic [15:0] mid_q, mid_d;
  logic [16:0] rem_q, rem_d;
  logic [3:0]  len_nib_q, len_nib_d;
  logic [7:0]  ext_hi_q, ext_hi_d;
  logic [15:0] acc_q, acc_d;
  logic [7:0]  path_q, path_d;

  coap_mp_pkg::role_e role;
  logic [7:0]  b;
  logic        last;
  logic        add_en, after_en, begin_en, val_en, path_en, path_fail;
  logic [16:0] add_val, begin_len;
  logic [17:0] acc_sum;
  logic [8:0]  path_sum;

  assign b    = item_i.data_byte;
  assign last = item_i.last_byte;

  always_comb begin
    phase_d   = phase_q;
    status_d  = status_q;
    hdr_idx_d = hdr_idx_q;
    type_d    = type_q;
    tok_len_d = tok_len_q;
    code_d    = code_q;
    mid_d     = mid_q;
    rem_d     = rem_q;
    len_nib_d = len_nib_q;
    ext_hi_d  = ext_hi_q;
    acc_d     = acc_q;
    path_d    = path_q;
    role      = coap_mp_pkg::ROLE_IGNORED;
    add_en    = 1'b0;
    add_val   = 17'd0;
    after_en  = 1'b0;
    begin_en  = 1'b0;
    begin_len = 17'd0;
    val_en    = 1'b0;
    path_en   = 1'b0;
    path_fail = 1'b0;
    acc_sum   = 18'd0;
    path_sum  = 9'd0;

    case (phase_q)
      coap_mp_pkg::PH_HDR: begin
        role = coap_mp_pkg::ROLE_HEADER;
        case (hdr_idx_q)
          2'd0: begin
            type_d    = b[5:4];
            tok_len_d = b[3:0];
            if (b[7:6] != coap_mp_pkg::COAP_VERSION) begin
              status_d = coap_mp_pkg::first_err(status_d, coap_mp_pkg::ST_VERSION);
              phase_d  = coap_mp_pkg::PH_IGN;
            end else if (b[3:0] > 4'(coap_mp_pkg::TOKEN_MAX)) begin
              status_d = coap_mp_pkg::first_err(status_d, coap_mp_pkg::ST_FORMAT);
              phase_d  = coap_mp_pkg::PH_IGN;
            end
          end
          2'd1:    code_d = b;
          default: mid_d  = {mid_q[7:0], b};
        endcase
        if (phase_d == coap_mp_pkg::PH_HDR) begin
          if (hdr_idx_q == 2'd3) begin
            hdr_idx_d = 2'd0;
            if (tok_len_d != 4'd0) begin
              rem_d   = {13'd0, tok_len_d};
              phase_d = coap_mp_pkg::PH_TOK;
            end else begin
              phase_d = coap_mp_pkg::PH_HEAD;
            end
          end else begin
            hdr_idx_d = hdr_idx_q + 2'd1;
          end
        end
      end
      coap_mp_pkg::PH_TOK: begin
        role  = coap_mp_pkg::ROLE_TOKEN;
        rem_d = rem_q - 17'd1;
        if (rem_q == 17'd1) phase_d = coap_mp_pkg::PH_HEAD;
      end
      coap_mp_pkg::PH_HEAD: begin
        if (b == coap_mp_pkg::MARKER_BYTE) begin
          role    = coap_mp_pkg::ROLE_MARKER;
          phase_d = coap_mp_pkg::PH_PAY;
          // marker with nothing after it
          if (last) begin
            status_d = coap_mp_pkg::first_err(status_d, coap_mp_pkg::ST_FORMAT);
            phase_d  = coap_mp_pkg::PH_IGN;
          end
        end else begin
          role      = coap_mp_pkg::ROLE_OPT_HD;
          len_nib_d = b[3:0];
          if (b[7:4] == coap_mp_pkg::NIB_RESERVED || b[3:0] == coap_mp_pkg::NIB_RESERVED) begin
            status_d = coap_mp_pkg::first_err(status_d, coap_mp_pkg::ST_FORMAT);
            phase_d  = coap_mp_pkg::PH_IGN;
          end else if (b[7:4] == coap_mp_pkg::NIB_EXT_1B) begin
            phase_d = coap_mp_pkg::PH_D13;
          end else if (b[7:4] == coap_mp_pkg::NIB_EXT_2B) begin
            phase_d = coap_mp_pkg::PH_D14H;
          end else begin
            add_en   = 1'b1;
            add_val  = {13'd0, b[7:4]};
            after_en = 1'b1;
          end
        end
      end
      coap_mp_pkg::PH_D13: begin
        role     = coap_mp_pkg::ROLE_OPT_EXT;
        add_en   = 1'b1;
        add_val  = {9'd0, b} + coap_mp_pkg::EXT_1B_OFFSET;
        after_en = 1'b1;
      end
      coap_mp_pkg::PH_D14H: begin
        role     = coap_mp_pkg::ROLE_OPT_EXT;
        ext_hi_d = b;
        phase_d  = coap_mp_pkg::PH_D14L;
      end
      coap_mp_pkg::PH_L14H: begin
        role     = coap_mp_pkg::ROLE_OPT_EXT;
        ext_hi_d = b;
        phase_d  = coap_mp_pkg::PH_L14L;
      end
      coap_mp_pkg::PH_D14L: begin
        role     = coap_mp_pkg::ROLE_OPT_EXT;
        add_en   = 1'b1;
        add_val  = {1'b0, ext_hi_q, b} + coap_mp_pkg::EXT_2B_OFFSET;
        after_en = 1'b1;
      end
      coap_mp_pkg::PH_L13: begin
        role      = coap_mp_pkg::ROLE_OPT_EXT;
        begin_en  = 1'b1;
        begin_len = {9'd0, b} + coap_mp_pkg::EXT_1B_OFFSET;
      end
      coap_mp_pkg::PH_L14L: begin
        role      = coap_mp_pkg::ROLE_OPT_EXT;
        begin_en  = 1'b1;
        begin_len = {1'b0, ext_hi_q, b} + coap_mp_pkg::EXT_2B_OFFSET;
      end
      coap_mp_pkg::PH_VAL: begin
        role   = coap_mp_pkg::ROLE_OPT_VAL;
        val_en = 1'b1;
      end
      coap_mp_pkg::PH_PAY: role = coap_mp_pkg::ROLE_PAYLOAD;
      default:             role = coap_mp_pkg::ROLE_IGNORED;
    endcase

    // option number, saturating
    if (add_en) begin
      acc_sum = {2'd0, acc_q} + {1'b0, add_val};
      acc_d   = (acc_sum[17:16] != 2'd0) ? 16'hFFFF : acc_sum[15:0];
    end

    // delta done: length extension or start of the value
    if (after_en) begin
      if (len_nib_d == coap_mp_pkg::NIB_EXT_1B) begin
        phase_d = coap_mp_pkg::PH_L13;
      end else if (len_nib_d == coap_mp_pkg::NIB_EXT_2B) begin
        phase_d = coap_mp_pkg::PH_L14H;
      end else begin
        begin_en  = 1'b1;
        begin_len = {13'd0, len_nib_d};
      end
    end

    // slash of a new path segment, or one of its bytes
    if ((begin_en || val_en) && acc_d == cfg_i.uri_option_number) path_en = 1'b1;
    if (path_en) begin
      path_sum = {1'b0, path_q} + 9'd1;
      path_d   = path_sum[8] ? 8'hFF : path_sum[7:0];
      if (path_sum > {1'b0, cfg_i.uri_max_length}) begin
        path_fail = 1'b1;
        status_d  = coap_mp_pkg::first_err(status_d, coap_mp_pkg::ST_PATH_LONG);
        phase_d   = coap_mp_pkg::PH_IGN;
      end
    end

    if (begin_en && !path_fail) begin
      if (begin_len == 17'd0) begin
        phase_d = coap_mp_pkg::PH_HEAD;
      end else begin
        rem_d   = begin_len;
        phase_d = coap_mp_pkg::PH_VAL;
      end
    end

    if (val_en && !path_fail) begin
      rem_d = rem_q - 17'd1;
      if (rem_q == 17'd1) phase_d = coap_mp_pkg::PH_HEAD;
    end

    // end of message checks
    if (last && status_d == coap_mp_pkg::ST_OK) begin
      if (phase_d != coap_mp_pkg::PH_HEAD && phase_d != coap_mp_pkg::PH_PAY) begin
        status_d = coap_mp_pkg::ST_TRUNCATED;
        phase_d  = coap_mp_pkg::PH_IGN;
      end else if (type_d == coap_mp_pkg::TYPE_ACK) begin
        status_d = coap_mp_pkg::ST_ACK;
      end else if (type_d == coap_mp_pkg::TYPE_RST) begin
        status_d = coap_mp_pkg::ST_BAD_TYPE;
      end
    end

    res_o.byte_role     = role;
    res_o.byte_value    = b;
    res_o.option_number = acc_d;
    res_o.message_done  = last;
    res_o.status        = status_d;
    res_o.msg_type      = type_d;
    res_o.token_length  = tok_len_d;
    res_o.request_code  = code_d;
    res_o.message_id    = mid_d;
    res_o.uri_path_len  = path_d;

    if (last) begin
      phase_d   = coap_mp_pkg::PH_HDR;
      status_d  = coap_mp_pkg::ST_OK;
      hdr_idx_d = 2'd0;
      type_d    = 2'd0;
      tok_len_d = 4'd0;
      code_d    = 8'd0;
      mid_d     = 16'd0;
      rem_d     = 17'd0;
      len_nib_d = 4'd0;
      ext_hi_d  = 8'd0;
      acc_d     = 16'd0;
      path_d    = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= coap_mp_pkg::PH_HDR;
      status_q  <= coap_mp_pkg::ST_OK;
      hdr_idx_q <= 2'd0;
      type_q    <= 2'd0;
      tok_len_q <= 4'd0;
      code_q    <= 8'd0;
      mid_q     <= 16'd0;
      rem_q     <= 17'd0;
      len_nib_q <= 4'd0;
      ext_hi_q  <= 8'd0;
      acc_q     <= 16'd0;
      path_q    <= 8'd0;
    end else if (en_i) begin
      phase_q   <= phase_d;
      status_q  <= status_d;
      hdr_idx_q <= hdr_idx_d;
      type_q    <= type_d;
      tok_len_q <= tok_len_d;
      code_q    <= code_d;
      mid_q     <= mid_d;
      rem_q     <= rem_d;
      len_nib_q <= len_nib_d;
      ext_hi_q  <= ext_hi_d;
      acc_q     <= acc_d;
      path_q    <= path_d;
    end
  end

endmodule

/* src/coap_message_parser_core.sv */
// A byte goes via the input register and the result register to the output.
// Throughput: one byte per cycle while out_stall_i is low; the parse state is
// updated in a single pass as a byte moves from the input register to the
// result register. Reset (rst_ni low, asynchronous) empties both registers,
// returns the parser to header byte zero and restores the register defaults.
module coap_message_parser_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  coap_mp_pkg::in_item_t            in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output coap_mp_pkg::out_item_t           out_item_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [coap_mp_pkg::APB_AW-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  coap_mp_pkg::cfg_t      cfg;
  coap_mp_pkg::in_item_t  in_q;
  coap_mp_pkg::out_item_t out_q, res;
  logic in_valid_q, in_valid_d;
  logic out_valid_q, out_valid_d;
  logic advance, in_accept;

  coap_mp_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  coap_mp_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // an item moves on when the result register is free or being emptied
  assign advance     = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o  = in_valid_q & ~advance;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign in_valid_d  = in_accept | (in_valid_q & ~advance);
  assign out_valid_d = advance | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) in_q <= in_item_i;
    if (advance)   out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register not filled after advance");

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> !in_stall_o)
    else $error("input stalled while result register empty");

  a_ignored_has_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.byte_role == coap_mp_pkg::ROLE_IGNORED)
      |-> out_q.status != coap_mp_pkg::ST_OK)
    else $error("ignored byte without an error status");

  a_trunc_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == coap_mp_pkg::ST_TRUNCATED) |-> out_q.message_done)
    else $error("truncation reported before the last byte");

endmodule
